FILE: rtl/ppd_pkg.sv
// ----------------------------------------------------------------------------
// ppd_pkg
// Shared widths and types for the point-to-plane distance pipeline.
// ----------------------------------------------------------------------------
package ppd_pkg;

    localparam int COORD_W = 24;   // Q11.12 coordinate
    localparam int DIFF_W  = 25;   // difference of two coordinates
    localparam int PROD_W  = 50;   // product of two differences
    localparam int NORM_W  = 51;   // normal component
    localparam int LIMB_W  = 26;   // multiplier slice
    localparam int DOT_W   = 78;   // one term of the dot product
    localparam int SUM_W   = 80;   // full dot product, signed
    localparam int MAG_W   = 78;   // magnitude of the dot product
    localparam int NN_W    = 104;  // squared norm of the normal
    localparam int SQ_W    = 156;  // square of the dot product
    localparam int REM_W   = 160;  // remainder of the root search
    localparam int PNN_W   = 130;  // distance times squared norm
    localparam int DIST_W  = 25;   // unsigned Q13.12 distance

    typedef struct packed {
        logic valid;
        logic degen;
    } t_ctl;

endpackage

FILE: rtl/ppd_geom.sv
// ----------------------------------------------------------------------------
// ppd_geom
// Eight-stage front end: edge vectors, cross product, dot product and
// squared norm of the normal, split into slices of at most 27 bits.
// ----------------------------------------------------------------------------
module ppd_geom
    import ppd_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_valid,
    input  logic signed [COORD_W-1:0] i_query_x,
    input  logic signed [COORD_W-1:0] i_query_y,
    input  logic signed [COORD_W-1:0] i_query_z,
    input  logic signed [COORD_W-1:0] i_base_x,
    input  logic signed [COORD_W-1:0] i_base_y,
    input  logic signed [COORD_W-1:0] i_base_z,
    input  logic signed [COORD_W-1:0] i_second_x,
    input  logic signed [COORD_W-1:0] i_second_y,
    input  logic signed [COORD_W-1:0] i_second_z,
    input  logic signed [COORD_W-1:0] i_third_x,
    input  logic signed [COORD_W-1:0] i_third_y,
    input  logic signed [COORD_W-1:0] i_third_z,
    output t_ctl                      o_ctl,
    output logic [MAG_W-1:0]          o_mag,
    output logic [NN_W-1:0]           o_nn
);

    localparam int NSTG = 8;

    logic signed [COORD_W-1:0] c_q [3];
    logic signed [COORD_W-1:0] c_b [3];
    logic signed [COORD_W-1:0] c_s [3];
    logic signed [COORD_W-1:0] c_t [3];

    logic                      r_vld [NSTG];
    logic signed [DIFF_W-1:0]  r1_u [3];
    logic signed [DIFF_W-1:0]  r1_v [3];
    logic signed [DIFF_W-1:0]  r1_w [3];
    logic signed [PROD_W-1:0]  r2_p [6];
    logic signed [DIFF_W-1:0]  r2_w [3];
    logic signed [NORM_W-1:0]  r3_n [3];
    logic signed [DIFF_W-1:0]  r3_w [3];
    logic signed [NORM_W-1:0]  r4_n [3];
    logic [NORM_W-1:0]         r4_m [3];
    logic signed [DIFF_W-1:0]  r4_w [3];
    logic signed [PROD_W-1:0]  r5_dh [3];
    logic signed [PROD_W+1:0]  r5_dl [3];
    logic [PROD_W-1:0]         r5_hh [3];
    logic [PROD_W:0]           r5_hl [3];
    logic [PROD_W+1:0]         r5_ll [3];
    logic signed [DOT_W-1:0]   r6_dot [3];
    logic [NN_W-1:0]           r6_sq [3];
    logic signed [SUM_W-1:0]   r7_s;
    logic [NN_W-1:0]           r7_nn;
    logic [MAG_W-1:0]          r8_mag;
    logic [NN_W-1:0]           r8_nn;
    logic                      r8_degen;

    assign c_q = '{i_query_x, i_query_y, i_query_z};
    assign c_b = '{i_base_x, i_base_y, i_base_z};
    assign c_s = '{i_second_x, i_second_y, i_second_z};
    assign c_t = '{i_third_x, i_third_y, i_third_z};

    // valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NSTG; i++) r_vld[i] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_valid;
            for (int i = 1; i < NSTG; i++) r_vld[i] <= r_vld[i-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r1_u[k] <= DIFF_W'(c_s[k]) - DIFF_W'(c_b[k]);
                r1_v[k] <= DIFF_W'(c_t[k]) - DIFF_W'(c_b[k]);
                r1_w[k] <= DIFF_W'(c_q[k]) - DIFF_W'(c_b[k]);
            end
            r2_p[0] <= r1_u[1] * r1_v[2];
            r2_p[1] <= r1_u[2] * r1_v[1];
            r2_p[2] <= r1_u[2] * r1_v[0];
            r2_p[3] <= r1_u[0] * r1_v[2];
            r2_p[4] <= r1_u[0] * r1_v[1];
            r2_p[5] <= r1_u[1] * r1_v[0];
            r2_w    <= r1_w;
            for (int k = 0; k < 3; k++) begin
                r3_n[k] <= NORM_W'(r2_p[2*k]) - NORM_W'(r2_p[2*k+1]);
                r4_n[k] <= r3_n[k];
                r4_m[k] <= r3_n[k][NORM_W-1] ? NORM_W'(-r3_n[k]) : NORM_W'(r3_n[k]);
                // signed dot: high slice is signed, low slice unsigned
                r5_dh[k] <= $signed(r4_n[k][NORM_W-1:LIMB_W]) * r4_w[k];
                r5_dl[k] <= $signed({1'b0, r4_n[k][LIMB_W-1:0]}) * r4_w[k];
                r5_hh[k] <= r4_m[k][NORM_W-1:LIMB_W] * r4_m[k][NORM_W-1:LIMB_W];
                r5_hl[k] <= r4_m[k][NORM_W-1:LIMB_W] * r4_m[k][LIMB_W-1:0];
                r5_ll[k] <= r4_m[k][LIMB_W-1:0] * r4_m[k][LIMB_W-1:0];
                r6_dot[k] <= (DOT_W'(r5_dh[k]) <<< LIMB_W) + DOT_W'(r5_dl[k]);
                r6_sq[k]  <= (NN_W'(r5_hh[k]) << (2*LIMB_W))
                           + (NN_W'(r5_hl[k]) << (LIMB_W+1))
                           + NN_W'(r5_ll[k]);
            end
            r3_w  <= r2_w;
            r4_w  <= r3_w;
            r7_s  <= SUM_W'(r6_dot[0]) + SUM_W'(r6_dot[1]) + SUM_W'(r6_dot[2]);
            r7_nn <= r6_sq[0] + r6_sq[1] + r6_sq[2];
            r8_mag   <= r7_s[SUM_W-1] ? MAG_W'(-r7_s) : MAG_W'(r7_s);
            r8_nn    <= r7_nn;
            r8_degen <= (r7_nn == '0);
        end
    end

    assign o_ctl.valid = r_vld[NSTG-1];
    assign o_ctl.degen = r8_degen;
    assign o_mag       = r8_mag;
    assign o_nn        = r8_nn;

endmodule

FILE: rtl/ppd_sqr.sv
// ----------------------------------------------------------------------------
// ppd_sqr
// Two-stage squarer for the dot product magnitude, three 26-bit slices.
// ----------------------------------------------------------------------------
module ppd_sqr
    import ppd_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  t_ctl             i_ctl,
    input  logic [MAG_W-1:0] i_mag,
    input  logic [NN_W-1:0]  i_nn,
    output t_ctl             o_ctl,
    output logic [SQ_W-1:0]  o_sq,
    output logic [NN_W-1:0]  o_nn
);

    localparam int PP_W = 2 * LIMB_W;

    logic [LIMB_W-1:0] c_a0, c_a1, c_a2;
    t_ctl              r1_ctl, r2_ctl;
    logic [PP_W-1:0]   r1_p00, r1_p01, r1_p02, r1_p11, r1_p12, r1_p22;
    logic [NN_W-1:0]   r1_nn, r2_nn;
    logic [SQ_W-1:0]   r2_sq;

    assign c_a0 = i_mag[LIMB_W-1:0];
    assign c_a1 = i_mag[2*LIMB_W-1:LIMB_W];
    assign c_a2 = i_mag[3*LIMB_W-1:2*LIMB_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_ctl.valid <= 1'b0;
            r2_ctl.valid <= 1'b0;
        end else if (i_en) begin
            r1_ctl.valid <= i_ctl.valid;
            r2_ctl.valid <= r1_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_ctl.degen <= i_ctl.degen;
            r2_ctl.degen <= r1_ctl.degen;
            r1_p00 <= c_a0 * c_a0;
            r1_p01 <= c_a0 * c_a1;
            r1_p02 <= c_a0 * c_a2;
            r1_p11 <= c_a1 * c_a1;
            r1_p12 <= c_a1 * c_a2;
            r1_p22 <= c_a2 * c_a2;
            r1_nn  <= i_nn;
            // cross terms appear twice, hence one extra bit of shift
            r2_sq <= SQ_W'(r1_p00)
                   + (SQ_W'(r1_p01) << (LIMB_W+1))
                   + (SQ_W'(r1_p02) << (2*LIMB_W+1))
                   + (SQ_W'(r1_p11) << (2*LIMB_W))
                   + (SQ_W'(r1_p12) << (3*LIMB_W+1))
                   + (SQ_W'(r1_p22) << (4*LIMB_W));
            r2_nn <= r1_nn;
        end
    end

    assign o_ctl = r2_ctl;
    assign o_sq  = r2_sq;
    assign o_nn  = r2_nn;

endmodule

FILE: rtl/ppd_root_step.sv
// ----------------------------------------------------------------------------
// ppd_root_step
// One bit of the distance search: try setting bit BIT of the distance and
// keep it when the scaled square still fits under the squared dot product.
// ----------------------------------------------------------------------------
module ppd_root_step
    import ppd_pkg::*;
#(
    parameter int BIT = 0
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  t_ctl              i_ctl,
    input  logic [REM_W-1:0]  i_rem,
    input  logic [PNN_W-1:0]  i_pnn,
    input  logic [NN_W-1:0]   i_nn,
    input  logic [DIST_W-1:0] i_dist,
    output t_ctl              o_ctl,
    output logic [REM_W-1:0]  o_rem,
    output logic [PNN_W-1:0]  o_pnn,
    output logic [NN_W-1:0]   o_nn,
    output logic [DIST_W-1:0] o_dist
);

    logic [REM_W-1:0]  c_trial;
    logic              c_take;
    logic [REM_W-1:0]  n_rem;
    logic [PNN_W-1:0]  n_pnn;
    logic [DIST_W-1:0] n_dist;

    t_ctl              r_ctl;
    logic [REM_W-1:0]  r_rem;
    logic [PNN_W-1:0]  r_pnn;
    logic [NN_W-1:0]   r_nn;
    logic [DIST_W-1:0] r_dist;

    // (d + 2^b)^2 nn - d^2 nn = 2^(b+1) d nn + 2^(2b) nn
    always_comb begin
        c_trial = (REM_W'(i_pnn) << (BIT+1)) + (REM_W'(i_nn) << (2*BIT));
        c_take  = (c_trial <= i_rem);
        n_rem   = c_take ? i_rem - c_trial : i_rem;
        n_pnn   = c_take ? i_pnn + (PNN_W'(i_nn) << BIT) : i_pnn;
        n_dist  = c_take ? i_dist | (DIST_W'(1) << BIT) : i_dist;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl.valid <= 1'b0;
        end else if (i_en) begin
            r_ctl.valid <= i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ctl.degen <= i_ctl.degen;
            r_rem       <= n_rem;
            r_pnn       <= n_pnn;
            r_nn        <= i_nn;
            r_dist      <= n_dist;
        end
    end

    assign o_ctl  = r_ctl;
    assign o_rem  = r_rem;
    assign o_pnn  = r_pnn;
    assign o_nn   = r_nn;
    assign o_dist = r_dist;

endmodule

FILE: rtl/point_plane_distance.sv
// ----------------------------------------------------------------------------
// point_plane_distance
// Distance from a query point to the plane through three points, Q11.12 in,
// unsigned Q13.12 out, truncated toward zero.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: i_valid / o_stall with twelve signed Q11.12 coordinates
//   (query point, then the three plane points). A beat is taken at a rising
//   edge with i_valid high and o_stall low.
//   Output channel: o_valid / i_stall with o_distance and o_degenerate. One
//   result beat per input beat, in order.
//   Pipeline: 8 geometry stages, 2 squarer stages, 25 search stages,
//   1 output register.
//   Throughput: one beat per cycle while o_stall is low; the bit-per-stage
//   distance search and sliced multipliers are fully pipelined.
//   Collinear plane points give distance 0 with o_degenerate set.
//   Reset (synchronous, active low) drops every item in flight and clears
//   o_valid; data registers are not cleared.
//   Stall: the output register plus one skid entry absorb a stalled result;
//   once the skid entry fills, o_stall rises and the whole pipeline holds.
// ----------------------------------------------------------------------------
module point_plane_distance
    import ppd_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic signed [COORD_W-1:0] i_query_x,
    input  logic signed [COORD_W-1:0] i_query_y,
    input  logic signed [COORD_W-1:0] i_query_z,
    input  logic signed [COORD_W-1:0] i_base_x,
    input  logic signed [COORD_W-1:0] i_base_y,
    input  logic signed [COORD_W-1:0] i_base_z,
    input  logic signed [COORD_W-1:0] i_second_x,
    input  logic signed [COORD_W-1:0] i_second_y,
    input  logic signed [COORD_W-1:0] i_second_z,
    input  logic signed [COORD_W-1:0] i_third_x,
    input  logic signed [COORD_W-1:0] i_third_y,
    input  logic signed [COORD_W-1:0] i_third_z,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [DIST_W-1:0]         o_distance,
    output logic                      o_degenerate
);

    logic c_en;

    t_ctl             c_geom_ctl;
    logic [MAG_W-1:0] c_mag;
    logic [NN_W-1:0]  c_geom_nn;

    // search chain, entry 0 feeds the top bit
    t_ctl              c_ctl  [DIST_W+1];
    logic [REM_W-1:0]  c_rem  [DIST_W+1];
    logic [PNN_W-1:0]  c_pnn  [DIST_W+1];
    logic [NN_W-1:0]   c_nn   [DIST_W+1];
    logic [DIST_W-1:0] c_dist [DIST_W+1];
    logic [SQ_W-1:0]   c_sq;

    logic [DIST_W-1:0] c_res_dist;
    logic              c_push;
    logic              c_pop;

    logic              r_out_valid;
    logic [DIST_W-1:0] r_out_dist;
    logic              r_out_degen;
    logic              r_skid_valid;
    logic [DIST_W-1:0] r_skid_dist;
    logic              r_skid_degen;

    // hold everything while the skid entry is occupied
    assign c_en    = !r_skid_valid;
    assign o_stall = r_skid_valid;

    ppd_geom u_geom (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (c_en),
        .i_valid    (i_valid),
        .i_query_x  (i_query_x),
        .i_query_y  (i_query_y),
        .i_query_z  (i_query_z),
        .i_base_x   (i_base_x),
        .i_base_y   (i_base_y),
        .i_base_z   (i_base_z),
        .i_second_x (i_second_x),
        .i_second_y (i_second_y),
        .i_second_z (i_second_z),
        .i_third_x  (i_third_x),
        .i_third_y  (i_third_y),
        .i_third_z  (i_third_z),
        .o_ctl      (c_geom_ctl),
        .o_mag      (c_mag),
        .o_nn       (c_geom_nn)
    );

    ppd_sqr u_sqr (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (c_en),
        .i_ctl   (c_geom_ctl),
        .i_mag   (c_mag),
        .i_nn    (c_geom_nn),
        .o_ctl   (c_ctl[0]),
        .o_sq    (c_sq),
        .o_nn    (c_nn[0])
    );

    // remainder starts at the squared dot product, distance at zero
    assign c_rem[0]  = REM_W'(c_sq);
    assign c_pnn[0]  = '0;
    assign c_dist[0] = '0;

    for (genvar g = 0; g < DIST_W; g++) begin : g_step
        ppd_root_step #(
            .BIT (DIST_W - 1 - g)
        ) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (c_en),
            .i_ctl   (c_ctl[g]),
            .i_rem   (c_rem[g]),
            .i_pnn   (c_pnn[g]),
            .i_nn    (c_nn[g]),
            .i_dist  (c_dist[g]),
            .o_ctl   (c_ctl[g+1]),
            .o_rem   (c_rem[g+1]),
            .o_pnn   (c_pnn[g+1]),
            .o_nn    (c_nn[g+1]),
            .o_dist  (c_dist[g+1])
        );
    end

    // a zero normal lets every trial pass; force the distance to zero
    assign c_res_dist = c_ctl[DIST_W].degen ? '0 : c_dist[DIST_W];
    assign c_push     = c_en && c_ctl[DIST_W].valid;
    assign c_pop      = r_out_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (c_pop) begin
                r_skid_valid <= 1'b0;
            end
        end else if (!r_out_valid || c_pop) begin
            r_out_valid <= c_push;
        end else if (c_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (c_pop) begin
                r_out_dist  <= r_skid_dist;
                r_out_degen <= r_skid_degen;
            end
        end else if (!r_out_valid || c_pop) begin
            r_out_dist  <= c_res_dist;
            r_out_degen <= c_ctl[DIST_W].degen;
        end else begin
            r_skid_dist  <= c_res_dist;
            r_skid_degen <= c_ctl[DIST_W].degen;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_distance   = r_out_dist;
    assign o_degenerate = r_out_degen;

    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_degenerate |-> o_distance == '0)
        else $error("degenerate result with nonzero distance");

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry full while output register empty");

    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_valid) |-> $past(r_out_valid && i_stall))
        else $error("skid entry filled without a stalled output");

    // first edge out of reset: nothing valid, nothing stalled
    a_reset_clear: assert property (@(posedge i_clk)
        i_rst_n && $past(!i_rst_n) |-> !o_valid && !o_stall)
        else $error("output valid or stall after reset");

endmodule

FILE: dv/point_plane_distance_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// point_plane_distance_tb
// Streams query points and plane triples through the distance pipeline and
// checks every result beat against an exact wide-integer prediction, under
// random gaps on the input side and random stalls on the output side.
// ----------------------------------------------------------------------------

typedef logic signed [ppd_pkg::COORD_W-1:0] coord_t;
typedef logic signed [127:0] wide_t;

typedef struct {
    logic [ppd_pkg::DIST_W-1:0] distance;
    logic                       degen;
} dist_result_t;

// Holds the predicted distances in beat order and checks each result beat.
class dist_scoreboard;
    dist_result_t pending[$];
    int           errors = 0;

    // Predict the distance for one accepted beat and queue it.
    function void note_point(coord_t c[12]);
        wide_t        u[3], v[3], w[3], n[3];
        wide_t        dot, nn;
        logic [255:0] dot_sq, nn_u, cw, prod;
        logic [24:0]  d, cand;
        dist_result_t r;
        for (int k = 0; k < 3; k++) begin
            u[k] = wide_t'(c[6+k]) - wide_t'(c[3+k]);
            v[k] = wide_t'(c[9+k]) - wide_t'(c[3+k]);
            w[k] = wide_t'(c[k])   - wide_t'(c[3+k]);
        end
        n[0] = u[1] * v[2] - u[2] * v[1];
        n[1] = u[2] * v[0] - u[0] * v[2];
        n[2] = u[0] * v[1] - u[1] * v[0];
        if (n[0] == 0 && n[1] == 0 && n[2] == 0) begin
            r.distance = '0;
            r.degen    = 1'b1;
        end else begin
            dot = n[0] * w[0] + n[1] * w[1] + n[2] * w[2];
            if (dot < 0) dot = -dot;
            nn     = n[0] * n[0] + n[1] * n[1] + n[2] * n[2];
            dot_sq = {128'b0, dot} * {128'b0, dot};
            nn_u   = {128'b0, nn};
            d      = '0;
            // Bitwise root search, largest d with d*d*|n|^2 <= dot^2.
            for (int b = 24; b >= 0; b--) begin
                cand = d | (25'd1 << b);
                cw   = {231'b0, cand};
                prod = cw * cw * nn_u;
                if (prod <= dot_sq) d = cand;
            end
            r.distance = d;
            r.degen    = 1'b0;
        end
        pending.push_back(r);
    endfunction

    function void check_result(logic [ppd_pkg::DIST_W-1:0] distance, logic degen);
        dist_result_t e;
        if (pending.size() == 0) begin
            $display("%0t: unexpected result distance=%0d degen=%0b",
                     $time, distance, degen);
            errors++;
            return;
        end
        e = pending.pop_front();
        if (distance !== e.distance) begin
            $display("%0t: distance mismatch expected %0d actual %0d",
                     $time, e.distance, distance);
            errors++;
        end
        if (degen !== e.degen) begin
            $display("%0t: degenerate mismatch expected %0b actual %0b",
                     $time, e.degen, degen);
            errors++;
        end
    endfunction
endclass

module point_plane_distance_tb;
    import ppd_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_valid;
    logic                      o_stall;
    logic signed [COORD_W-1:0] i_query_x, i_query_y, i_query_z;
    logic signed [COORD_W-1:0] i_base_x, i_base_y, i_base_z;
    logic signed [COORD_W-1:0] i_second_x, i_second_y, i_second_z;
    logic signed [COORD_W-1:0] i_third_x, i_third_y, i_third_z;
    logic                      o_valid;
    logic                      i_stall;
    logic [DIST_W-1:0]         o_distance;
    logic                      o_degenerate;

    dist_scoreboard sb;
    bit             calm;     // no gaps and no stalls while set
    int unsigned    cycles = 0;

    point_plane_distance uut (.*);

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Watchdog: end the run once the cycle count passes CYCLE_LIMIT.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Check every result beat taken at this edge.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) sb.check_result(o_distance, o_degenerate);
    end

    // Output side: stall for a random count before each result, then release.
    initial begin
        int k;
        i_stall = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            k = calm ? 0 : $urandom_range(0, 6);
            if (k > 0) begin
                i_stall <= 1'b1;
                repeat (k) @(negedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    // Drive one beat: hold it until the block takes it, then note it.
    // Called at a falling edge; returns at a falling edge.
    task automatic send_point(coord_t c[12]);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_query_x  <= c[0];  i_query_y  <= c[1];  i_query_z  <= c[2];
        i_base_x   <= c[3];  i_base_y   <= c[4];  i_base_z   <= c[5];
        i_second_x <= c[6];  i_second_y <= c[7];  i_second_z <= c[8];
        i_third_x  <= c[9];  i_third_y  <= c[10]; i_third_z  <= c[11];
        i_valid    <= 1'b1;
        do @(posedge i_clk); while (o_stall);
        sb.note_point(c);
        @(negedge i_clk);
    endtask

    function automatic coord_t rnd_full();
        return coord_t'($urandom());
    endfunction

    function automatic coord_t rnd_near(int span);
        return coord_t'($urandom_range(0, 2 * span) - span);
    endfunction

    task automatic send_random();
        coord_t c[12];
        int     mode, k;
        coord_t dx, dy, dz;
        mode = $urandom_range(0, 9);
        for (int i = 0; i < 12; i++) c[i] = rnd_full();
        case (mode)
            0, 1, 2: begin
                // Keep full-range coordinates.
            end
            3, 4: begin
                // Cluster around the origin so distances stay moderate.
                for (int i = 0; i < 12; i++) c[i] = rnd_near(4096);
            end
            5: begin
                // Build collinear plane points.
                for (int i = 3; i < 6; i++) c[i] = rnd_near(1 << 22);
                dx = rnd_near(1000); dy = rnd_near(1000); dz = rnd_near(1000);
                k = $urandom_range(0, 6) - 3;
                c[6]  = c[3] + dx;
                c[7]  = c[4] + dy;
                c[8]  = c[5] + dz;
                c[9]  = coord_t'(c[3] + k * dx);
                c[10] = coord_t'(c[4] + k * dy);
                c[11] = coord_t'(c[5] + k * dz);
            end
            6: begin
                // Place the query on a plane point.
                k = 3 * $urandom_range(1, 3);
                c[0] = c[k]; c[1] = c[k+1]; c[2] = c[k+2];
            end
            7: begin
                // Pick only extreme values.
                for (int i = 0; i < 12; i++)
                    c[i] = $urandom_range(0, 1) ? 24'sh7FFFFF : 24'sh800000;
            end
            default: begin
                // Short plane edges with a far query: large distances.
                for (int i = 3; i < 12; i++) c[i] = rnd_near(8);
                for (int i = 0; i < 3; i++) c[i] = rnd_full();
            end
        endcase
        send_point(c);
    endtask

    task automatic send_directed();
        coord_t c[12];
        coord_t mx, mn;
        mx = 24'sh7FFFFF;
        mn = 24'sh800000;
        // All zero: every plane point equal.
        c = '{default: 0};
        send_point(c);
        // Unit triangle in the xy plane, query above it.
        c = '{0, 0, 4096, 0, 0, 0, 4096, 0, 0, 0, 4096, 0};
        send_point(c);
        // Query below the plane.
        c = '{100, 200, -4096, 0, 0, 0, 4096, 0, 0, 0, 4096, 0};
        send_point(c);
        // Query on the plane.
        c = '{1234, -5678, 0, 0, 0, 0, 4096, 0, 0, 0, 4096, 0};
        send_point(c);
        // Collinear points along a diagonal.
        c = '{5, 6, 7, 1, 1, 1, 2, 2, 2, 9, 9, 9};
        send_point(c);
        // Two plane points coincide.
        c = '{mx, mx, mx, 10, 20, 30, 10, 20, 30, -4, 8, 1};
        send_point(c);
        // Extremes: widest plane, farthest query.
        c = '{mx, mx, mx, mn, mn, mn, mx, mn, mn, mn, mx, mn};
        send_point(c);
        c = '{mn, mn, mn, mx, mx, mx, mn, mx, mx, mx, mn, mx};
        send_point(c);
        // Tiny plane, far query: largest distance.
        c = '{mx, mx, mx, mn, mn, mn, mn + 1, mn, mn, mn, mn + 1, mn};
        send_point(c);
        c = '{mn, mn, mn, mx, mx, mx, mx - 1, mx, mx, mx, mx - 1, mx};
        send_point(c);
        // All minimum, all maximum.
        c = '{default: mn};
        send_point(c);
        c = '{default: mx};
        send_point(c);
        // Tilted plane with all-ones style patterns.
        c = '{-1, -1, -1, 24'sh555555, 24'shAAAAAA, 0, 24'sh0F0F0F, 1, -1,
              24'shF0F0F0, -2, 2};
        send_point(c);
    endtask

    initial begin
        sb      = new();
        calm    = 1'b0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        {i_query_x, i_query_y, i_query_z, i_base_x, i_base_y, i_base_z} = '0;
        {i_second_x, i_second_y, i_second_z, i_third_x, i_third_y, i_third_z} = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        send_directed();
        for (int i = 0; i < 1400; i++) begin
            // Run back-to-back stretches now and then.
            if (i % 200 == 100) calm = 1'b1;
            if (i % 200 == 160) calm = 1'b0;
            if (i == 700) begin
                // Drain the pipeline before resuming.
                i_valid <= 1'b0;
                while (sb.pending.size() != 0) @(negedge i_clk);
            end
            send_random();
        end
        i_valid <= 1'b0;
        calm = 1'b0;

        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (60) @(negedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
